// ===== hw/rtl/wcme_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcme_pkg
// Shared constants, types and helpers of the weighted cut minimum engine.
// ----------------------------------------------------------------------------
package wcme_pkg;

    localparam int MAX_VERTICES = 8;
    localparam int VTX_BITS     = $clog2(MAX_VERTICES);
    localparam int CUT_MAX      = MAX_VERTICES * MAX_VERTICES * 2;
    localparam int CUT_BITS     = 7;
    localparam int NC_BITS      = CUT_BITS + 1;
    localparam int WEIGHT_BITS  = 16;
    localparam int VALUE_BITS   = 40;
    localparam int NB_BITS      = 20;
    localparam int PROD_BITS    = WEIGHT_BITS + NB_BITS;
    localparam int SQ_BITS      = 2 * WEIGHT_BITS;
    localparam int COUNT_BITS   = 8;
    localparam int ADJ_BITS     = 28;
    localparam int VCNT_BITS    = 4;
    localparam int PH_BITS      = 4;
    localparam int CFG_IDX_BITS = 1;
    localparam int S_DATA_BITS  = 24;
    localparam int M_DATA_BITS  = 88;

    // build phases of one cut
    localparam logic [PH_BITS-1:0] PH_ROW      = 4'd0;
    localparam logic [PH_BITS-1:0] PH_MUL_LAST = 4'd8;
    localparam logic [PH_BITS-1:0] PH_ACC_LAST = 4'd9;
    localparam logic [PH_BITS-1:0] PH_WRITE    = 4'd10;

    typedef enum logic [1:0] {
        CMD_LOAD     = 2'd0,
        CMD_TRIAL    = 2'd1,
        CMD_COMMIT   = 2'd2,
        CMD_RESERVED = 2'd3
    } cmd_t;

    localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_COUNT = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ADJACENCY    = 1'd1;

    typedef logic [MAX_VERTICES-1:0][NB_BITS-1:0] nb_row_t;

    typedef struct packed {
        logic capture;
        logic wr_weight;
        logic build_start;
        logic scan_start;
        logic scan_commit;
        logic out_load;
        logic out_reject;
    } dp_cmd_t;

    typedef struct packed {
        logic bad;
        logic done;
    } dp_status_t;

    // edge i<j lives at bit j*(j-1)/2+i
    function automatic logic edge_bit(input logic [ADJ_BITS-1:0] adj, input int i,
                                      input int j);
        int lo;
        int hi;
        int idx;
        lo = (i < j) ? i : j;
        hi = (i < j) ? j : i;
        idx = hi * (hi - 1) / 2 + lo;
        if (lo == hi || idx >= ADJ_BITS) begin
            return 1'b0;
        end
        return adj[idx];
    endfunction

endpackage

// ===== hw/rtl/weighted_cut_minimum_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_cut_minimum_engine_top
// Same-side cut table engine: weight load, table build, trial and commit moves.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  tuser: cmd; tdata: vertex_a, vertex_b, amount;
//                                            tlast: last_weight
//  m_*       out        m_tvalid / m_tready  tdata: min_value, min_count, next_value;
//                                            tuser: status
//  cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data (one register a transfer)
//
//  Load without last_weight only stores the weight. Load with last_weight builds
//  the tables cut by cut, each in row, multiply, accumulate and write phases, paced
//  by the single shared weight x neighbour-sum multiplier; m_tvalid follows the build.
//  Trial or commit: one cut a cycle; a rejected move is answered without a scan.
//  Reset is synchronous; the tables are not cleared, only marked not built.
//  A finished result waits in the output register, and a new transfer is taken
//  meanwhile; the next result stalls until that register is free.
// ----------------------------------------------------------------------------
module weighted_cut_minimum_engine_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [wcme_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [wcme_pkg::ADJ_BITS-1:0]         cfg_data,
    // commands
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [wcme_pkg::S_DATA_BITS-1:0]      s_tdata,  // a[2:0] b[5:3] amount[21:6], 0
    input  logic [1:0]                            s_tuser,  // cmd[1:0]
    input  logic                                  s_tlast,  // last_weight
    // results
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [wcme_pkg::M_DATA_BITS-1:0]      m_tdata,  // min[39:0] count[47:40] next[87:48]
    output logic                                  m_tuser   // status
);

    wcme_pkg::dp_cmd_t                  dp_cmd;
    wcme_pkg::dp_status_t               dp_status;
    logic [wcme_pkg::VALUE_BITS-1:0]    out_min, out_next;
    logic [wcme_pkg::COUNT_BITS-1:0]    out_count;

    // registers are to be changed only while idle; the block does not enforce it, and every write is taken at once
    assign cfg_ready = 1'b1;
    assign m_tdata   = {out_next, out_count, out_min};

    wcme_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_cmd     (s_tuser),
        .s_last    (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status)
    );

    wcme_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_a       (s_tdata[2:0]),
        .in_b       (s_tdata[5:3]),
        .in_amount  (s_tdata[21:6]),
        .dp_cmd     (dp_cmd),
        .dp_status  (dp_status),
        .out_min    (out_min),
        .out_count  (out_count),
        .out_next   (out_next),
        .out_status (m_tuser)
    );

endmodule

// ===== hw/rtl/wcme_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcme_ctrl
// Command sequencer: input handshake, pass control and result register valid.
// ----------------------------------------------------------------------------
module wcme_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [1:0]           s_cmd,
    input  logic                 s_last,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output wcme_pkg::dp_cmd_t    dp_cmd,
    input  wcme_pkg::dp_status_t dp_status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_BUILD,
        ST_SCAN,
        ST_REPLY
    } state_t;

    state_t state_reg;
    logic   commit_reg;
    logic   reject_reg;
    logic   m_tvalid_reg;
    logic   accept;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        dp_cmd             = '0;
        dp_cmd.capture     = accept;
        dp_cmd.wr_weight   = accept && (s_cmd == wcme_pkg::CMD_LOAD);
        dp_cmd.build_start = accept && (s_cmd == wcme_pkg::CMD_LOAD) && s_last;
        dp_cmd.scan_start  = (state_reg == ST_CHECK) && !dp_status.bad;
        dp_cmd.scan_commit = commit_reg;
        dp_cmd.out_load    = (state_reg == ST_REPLY) && out_free;
        dp_cmd.out_reject  = reject_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            commit_reg   <= 1'b0;
            reject_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        case (s_cmd)
                            wcme_pkg::CMD_LOAD: begin
                                if (s_last) begin
                                    state_reg <= ST_BUILD;
                                end
                            end
                            wcme_pkg::CMD_TRIAL,
                            wcme_pkg::CMD_COMMIT: begin
                                commit_reg <= (s_cmd == wcme_pkg::CMD_COMMIT);
                                state_reg  <= ST_CHECK;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CHECK: begin
                    reject_reg <= dp_status.bad;
                    state_reg  <= dp_status.bad ? ST_REPLY : ST_SCAN;
                end
                ST_BUILD: begin
                    reject_reg <= 1'b0;
                    if (dp_status.done) begin
                        state_reg <= ST_REPLY;
                    end
                end
                ST_SCAN: begin
                    if (dp_status.done) begin
                        state_reg <= ST_REPLY;
                    end
                end
                ST_REPLY: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten while held");
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_status.done |-> (state_reg == ST_BUILD || state_reg == ST_SCAN))
        else $error("pass finished outside a pass");
    a_move_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_cmd == wcme_pkg::CMD_TRIAL || s_cmd == wcme_pkg::CMD_COMMIT))
        |=> (state_reg == ST_CHECK))
        else $error("move not checked");
`endif

endmodule

// ===== hw/rtl/wcme_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcme_datapath
// Weights, cut and neighbour tables, build and scan passes, running summary.
// ----------------------------------------------------------------------------
module wcme_datapath (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_valid,
    input  logic [wcme_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [wcme_pkg::ADJ_BITS-1:0]           cfg_data,
    input  logic [wcme_pkg::VTX_BITS-1:0]           in_a,
    input  logic [wcme_pkg::VTX_BITS-1:0]           in_b,
    input  logic [wcme_pkg::WEIGHT_BITS-1:0]        in_amount,
    input  wcme_pkg::dp_cmd_t                       dp_cmd,
    output wcme_pkg::dp_status_t                    dp_status,
    output logic [wcme_pkg::VALUE_BITS-1:0]         out_min,
    output logic [wcme_pkg::COUNT_BITS-1:0]         out_count,
    output logic [wcme_pkg::VALUE_BITS-1:0]         out_next,
    output logic                                    out_status
);

    localparam int NV = wcme_pkg::MAX_VERTICES;
    localparam int VB = wcme_pkg::VALUE_BITS;
    localparam int WB = wcme_pkg::WEIGHT_BITS;
    localparam int NB = wcme_pkg::NB_BITS;
    localparam int CB = wcme_pkg::CUT_BITS;

    logic [WB-1:0]                    weight_reg [NV];
    logic [wcme_pkg::VCNT_BITS-1:0]   vcount_reg;
    logic [wcme_pkg::ADJ_BITS-1:0]    adj_reg;
    logic                             tv_reg;
    logic [wcme_pkg::VTX_BITS-1:0]    a_reg, b_reg;
    logic [WB-1:0]                    d_reg;
    logic [wcme_pkg::SQ_BITS-1:0]     dd_reg;

    wcme_pkg::nb_row_t                nb_mem [wcme_pkg::CUT_MAX];
    logic [VB-1:0]                    cut_mem [wcme_pkg::CUT_MAX];

    logic [wcme_pkg::VCNT_BITS-1:0]   h;
    logic [wcme_pkg::NC_BITS-1:0]     nc;
    logic [CB-1:0]                    last_cut;
    logic [NV-1:0]                    active;
    logic [NV-1:0]                    edge_m [NV];

    // config and derived shape
    always_comb begin
        if (vcount_reg < 4'd2) begin
            h = 4'd2;
        end else if (vcount_reg > 4'(NV)) begin
            h = 4'(NV);
        end else begin
            h = vcount_reg;
        end
        nc       = wcme_pkg::NC_BITS'(1) << (h - 4'd1);
        last_cut = CB'(nc - wcme_pkg::NC_BITS'(1));
        for (int i = 0; i < NV; i++) begin
            active[i] = (4'(i) < h);
            for (int j = 0; j < NV; j++) begin
                edge_m[i][j] = wcme_pkg::edge_bit(adj_reg, i, j);
            end
        end
    end

    // ---------------- build pass ----------------
    logic                             b_active_reg;
    logic [CB-1:0]                    b_cut_reg;
    logic [wcme_pkg::PH_BITS-1:0]     b_ph_reg;
    logic [NB-1:0]                    nbu_reg [NV];
    logic [wcme_pkg::PROD_BITS-1:0]   prod_reg;
    logic [VB-1:0]                    acc_reg;
    wcme_pkg::nb_row_t                row_full;
    logic [NB-1:0]                    row_up [NV];
    logic [NV:0]                      sd_b;
    logic [wcme_pkg::VTX_BITS-1:0]    mul_i;
    logic                             b_write;
    logic                             b_done;

    always_comb begin
        sd_b = {b_cut_reg, 1'b0};
        for (int i = 0; i < NV; i++) begin
            row_full[i] = '0;
            row_up[i]   = '0;
            for (int j = 0; j < NV; j++) begin
                if (edge_m[i][j] && active[i] && active[j] && (sd_b[i] == sd_b[j])) begin
                    row_full[i] = row_full[i] + NB'(weight_reg[j]);
                    if (j > i) begin
                        row_up[i] = row_up[i] + NB'(weight_reg[j]);
                    end
                end
            end
        end
        mul_i   = wcme_pkg::VTX_BITS'(b_ph_reg - 4'd1);
        b_write = b_active_reg && (b_ph_reg == wcme_pkg::PH_WRITE);
        b_done  = b_write && (b_cut_reg == last_cut);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_active_reg <= 1'b0;
        end else if (dp_cmd.build_start) begin
            b_active_reg <= 1'b1;
        end else if (b_done) begin
            b_active_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.build_start) begin
            b_cut_reg <= '0;
            b_ph_reg  <= wcme_pkg::PH_ROW;
        end else if (b_active_reg) begin
            if (b_ph_reg == wcme_pkg::PH_ROW) begin
                for (int i = 0; i < NV; i++) begin
                    nbu_reg[i] <= row_up[i];
                end
                acc_reg <= '0;
            end
            if (b_ph_reg != wcme_pkg::PH_ROW && b_ph_reg <= wcme_pkg::PH_MUL_LAST) begin
                prod_reg <= weight_reg[mul_i] * nbu_reg[mul_i];
            end
            if (b_ph_reg > 4'd1 && b_ph_reg <= wcme_pkg::PH_ACC_LAST) begin
                acc_reg <= acc_reg + VB'(prod_reg);
            end
            if (b_write) begin
                b_ph_reg  <= wcme_pkg::PH_ROW;
                b_cut_reg <= b_cut_reg + CB'(1);
            end else begin
                b_ph_reg <= b_ph_reg + 4'd1;
            end
        end
    end

    // ---------------- scan pass ----------------
    logic                             sc_active_reg;
    logic                             sc_commit_reg;
    logic [wcme_pkg::NC_BITS-1:0]     sc_cnt_reg;
    logic                             sc_issue;
    logic                             v1_reg, v2_reg, v3_reg;
    logic [CB-1:0]                    idx1_reg, idx2_reg, idx3_reg;
    wcme_pkg::nb_row_t                nb_rd_reg, row2_reg, row_new;
    logic [VB-1:0]                    cut_rd_reg, cut2_reg, t_reg, t_next;
    logic [wcme_pkg::PROD_BITS-1:0]   pa_reg, pb_reg;
    logic [NV:0]                      sd_2;
    logic                             sc_done;

    assign sc_issue = sc_active_reg && (sc_cnt_reg <= {1'b0, last_cut});
    assign sc_done  = v3_reg && (idx3_reg == last_cut);

    always_comb begin
        sd_2   = {idx2_reg, 1'b0};
        t_next = cut2_reg + VB'(pb_reg) - VB'(pa_reg);
        if (edge_m[a_reg][b_reg] && (sd_2[a_reg] == sd_2[b_reg])) begin
            t_next = t_next - VB'(dd_reg);
        end
        for (int k = 0; k < NV; k++) begin
            row_new[k] = row2_reg[k];
            if (edge_m[a_reg][k] && active[k] && (sd_2[a_reg] == sd_2[k])) begin
                row_new[k] = row_new[k] - NB'(d_reg);
            end
            if (edge_m[b_reg][k] && active[k] && (sd_2[b_reg] == sd_2[k])) begin
                row_new[k] = row_new[k] + NB'(d_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sc_active_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
        end else begin
            if (dp_cmd.scan_start) begin
                sc_active_reg <= 1'b1;
            end else if (sc_done) begin
                sc_active_reg <= 1'b0;
            end
            v1_reg <= sc_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.scan_start) begin
            sc_cnt_reg    <= '0;
            sc_commit_reg <= dp_cmd.scan_commit;
        end else if (sc_issue) begin
            sc_cnt_reg <= sc_cnt_reg + wcme_pkg::NC_BITS'(1);
        end
        idx1_reg <= sc_cnt_reg[CB-1:0];
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        pa_reg   <= d_reg * nb_rd_reg[a_reg];
        pb_reg   <= d_reg * nb_rd_reg[b_reg];
        cut2_reg <= cut_rd_reg;
        row2_reg <= nb_rd_reg;
        t_reg    <= t_next;
        dd_reg   <= d_reg * d_reg;
    end

    // ---------------- table memories ----------------
    always_ff @(posedge aclk) begin
        nb_rd_reg  <= nb_mem[sc_cnt_reg[CB-1:0]];
        cut_rd_reg <= cut_mem[sc_cnt_reg[CB-1:0]];
        if (b_active_reg && b_ph_reg == wcme_pkg::PH_ROW) begin
            nb_mem[b_cut_reg] <= row_full;
        end else if (v2_reg && sc_commit_reg) begin
            nb_mem[idx2_reg] <= row_new;
        end
        if (b_write) begin
            cut_mem[b_cut_reg] <= acc_reg;
        end else if (v3_reg && sc_commit_reg) begin
            cut_mem[idx3_reg] <= t_reg;
        end
    end

    // ---------------- weights, config, fields ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NV; i++) begin
                weight_reg[i] <= '0;
            end
            vcount_reg <= 4'd2;
            adj_reg    <= '0;
            tv_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                tv_reg <= 1'b0;
                case (cfg_index)
                    wcme_pkg::REG_VERTEX_COUNT: vcount_reg <= cfg_data[wcme_pkg::VCNT_BITS-1:0];
                    wcme_pkg::REG_ADJACENCY:    adj_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (dp_cmd.wr_weight) begin
                weight_reg[in_a] <= in_amount;
                tv_reg           <= 1'b0;
            end
            if (b_done) begin
                tv_reg <= 1'b1;
            end
            if (dp_cmd.scan_start && dp_cmd.scan_commit) begin
                weight_reg[a_reg] <= weight_reg[a_reg] - d_reg;
                weight_reg[b_reg] <= weight_reg[b_reg] + d_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.capture) begin
            a_reg <= in_a;
            b_reg <= in_b;
            d_reg <= in_amount;
        end
    end

    always_comb begin
        dp_status.bad = !tv_reg || ({1'b0, a_reg} >= h) || ({1'b0, b_reg} >= h)
                        || (a_reg == b_reg) || (d_reg > weight_reg[a_reg])
                        || (({1'b0, weight_reg[b_reg]} + {1'b0, d_reg}) > {1'b0, {WB{1'b1}}});
        dp_status.done = b_done || sc_done;
    end

    // ---------------- running summary ----------------
    logic [VB-1:0]                    mn_reg, nx_reg, f_val;
    logic [wcme_pkg::COUNT_BITS-1:0]  cnt_reg;
    logic                             hn_reg;
    logic                             f_valid, f_first;

    assign f_valid = b_write || v3_reg;
    assign f_val   = b_write ? acc_reg : t_reg;
    assign f_first = b_write ? (b_cut_reg == '0) : (idx3_reg == '0);

    always_ff @(posedge aclk) begin
        if (f_valid) begin
            if (f_first) begin
                mn_reg  <= f_val;
                cnt_reg <= 8'd1;
                hn_reg  <= 1'b0;
            end else if (f_val < mn_reg) begin
                nx_reg  <= mn_reg;
                hn_reg  <= 1'b1;
                mn_reg  <= f_val;
                cnt_reg <= 8'd1;
            end else if (f_val == mn_reg) begin
                cnt_reg <= cnt_reg + 8'd1;
            end else if (!hn_reg || f_val < nx_reg) begin
                nx_reg <= f_val;
                hn_reg <= 1'b1;
            end
        end
        if (dp_cmd.out_load) begin
            if (dp_cmd.out_reject) begin
                out_min    <= '0;
                out_count  <= '0;
                out_next   <= '0;
                out_status <= 1'b1;
            end else begin
                out_min    <= mn_reg;
                out_count  <= cnt_reg;
                out_next   <= hn_reg ? nx_reg : {VB{1'b1}};
                out_status <= 1'b0;
            end
        end
    end

endmodule
